// File: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

  // Event and host operation codes carried on the opcode field.
  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_READBACK  = 3'd1,
    OP_GO        = 3'd2,
    OP_START_SENT = 3'd3,
    OP_ADDR_SENT = 3'd4,
    OP_RX_READY  = 3'd5,
    OP_TX_EMPTY  = 3'd6
  } opcode_t;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_TARGET_ADDR = 2'd0,
    REG_XFER_KIND   = 2'd1,
    REG_WRITE_LEN   = 2'd2,
    REG_READ_LEN    = 2'd3
  } reg_index_t;

  localparam int PtrW = 6;
  localparam logic [5:0] ReadLenReset = 6'd1;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0] target_address;
    logic       transfer_kind;
    logic [5:0] write_length;
    logic [5:0] read_length;
  } cfg_t;

  // Buffer access request for one step.
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic [5:0] rd_addr;
  } buf_req_t;

  // Result of one step, before the buffer read data is merged in.
  typedef struct packed {
    logic       tx_valid;
    logic       tx_from_buf;
    logic [7:0] addr_byte;
    logic       start_request;
    logic       stop_request;
    logic       ack_enable;
    logic       busy;
    logic       readback;
  } step_res_t;

endpackage

// File: rtl/core/i2cms_buf.sv
module i2cms_buf import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk,
  input  logic       step,
  input  buf_req_t   req,
  output logic [7:0] rd_data,
  output logic       rd_ok
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int XW = ((AW > PtrW) ? AW : PtrW) + 1;

  logic [7:0]    mem [BUF_DEPTH];
  logic [XW-1:0] wr_ext;
  logic [XW-1:0] rd_ext;
  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;

  // Range check against the buffer depth; out-of-range writes are dropped
  // and out-of-range reads return zero.
  always_comb begin
    wr_ext      = XW'(req.wr_addr);
    rd_ext      = XW'(req.rd_addr);
    wr_in_range = wr_ext < XW'(BUF_DEPTH);
    rd_in_range = rd_ext < XW'(BUF_DEPTH);
    wr_idx      = wr_ext[AW-1:0];
    rd_idx      = rd_ext[AW-1:0];
  end

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in_range) begin
      mem[wr_idx] <= req.wr_data;
    end
    if (step) begin
      rd_data <= mem[rd_idx];
      rd_ok   <= rd_in_range;
    end
  end

endmodule

// File: rtl/core/i2cms_ctrl.sv
module i2cms_ctrl import i2cms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [2:0] opcode,
  input  logic [4:0] buffer_index,
  input  logic [7:0] data_in,
  input  cfg_t       cfg,
  output buf_req_t   req,
  output step_res_t  res
);

  logic [5:0] byte_pointer;
  logic [5:0] byte_pointer_next;
  logic       read_phase;
  logic       read_phase_next;
  logic       busy_flag;
  logic       busy_flag_next;
  logic       ack_level;
  logic       ack_level_next;
  logic [5:0] ptr_inc;

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pointer <= '0;
      read_phase   <= 1'b0;
      busy_flag    <= 1'b1;
      ack_level    <= 1'b0;
    end else if (step) begin
      byte_pointer <= byte_pointer_next;
      read_phase   <= read_phase_next;
      busy_flag    <= busy_flag_next;
      ack_level    <= ack_level_next;
    end
  end

  // Event decode: next state, buffer access and the step result.
  always_comb begin
    ptr_inc           = 6'(byte_pointer + 6'd1);
    byte_pointer_next = byte_pointer;
    read_phase_next   = read_phase;
    busy_flag_next    = busy_flag;
    ack_level_next    = ack_level;
    req               = '0;
    req.wr_data       = data_in;
    req.rd_addr       = byte_pointer;
    res               = '0;

    unique case (opcode)
      OP_LOAD: begin
        req.wr_en   = step;
        req.wr_addr = {1'b0, buffer_index};
      end
      OP_READBACK: begin
        req.rd_addr  = {1'b0, buffer_index};
        res.readback = 1'b1;
      end
      OP_GO: begin
        busy_flag_next    = 1'b1;
        res.start_request = 1'b1;
      end
      OP_START_SENT: begin
        res.tx_valid  = 1'b1;
        res.addr_byte = {cfg.target_address, read_phase};
      end
      OP_ADDR_SENT: begin
        byte_pointer_next = '0;
        ack_level_next    = 1'b1;
        req.rd_addr       = '0;
        if (!read_phase) begin
          if (cfg.write_length != '0) begin
            res.tx_valid      = 1'b1;
            res.tx_from_buf   = 1'b1;
            byte_pointer_next = 6'd1;
          end
        end else if (cfg.read_length == 6'd1) begin
          ack_level_next   = 1'b0;
          res.stop_request = 1'b1;
        end
      end
      OP_RX_READY: begin
        // Nack and stop ahead of the last byte of the read phase.
        if (cfg.read_length == 6'd1) begin
          read_phase_next = 1'b0;
        end else if (byte_pointer == 6'(cfg.read_length - 6'd2)) begin
          ack_level_next   = 1'b0;
          res.stop_request = 1'b1;
          read_phase_next  = 1'b0;
        end
        req.wr_en         = step;
        req.wr_addr       = byte_pointer;
        byte_pointer_next = ptr_inc;
        if (ptr_inc == cfg.read_length) begin
          busy_flag_next = 1'b0;
        end
      end
      OP_TX_EMPTY: begin
        if (byte_pointer < cfg.write_length) begin
          if (!cfg.transfer_kind && byte_pointer == 6'(cfg.write_length - 6'd1)) begin
            res.stop_request = 1'b1;
          end
          res.tx_valid      = 1'b1;
          res.tx_from_buf   = 1'b1;
          byte_pointer_next = ptr_inc;
        end else if (cfg.transfer_kind) begin
          // Write phase done: go to the repeated-start read phase.
          read_phase_next   = 1'b1;
          busy_flag_next    = 1'b1;
          res.start_request = 1'b1;
        end else begin
          busy_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.ack_enable = ack_level_next;
    res.busy       = busy_flag_next;
  end

endmodule

// File: rtl/core/i2c_master_transfer_sequencer_core.sv
// Channel   Handshake                 Payload
// input     in_valid / in_stall       opcode, buffer_index, data_in
// output    out_valid / out_stall     tx_valid, tx_byte, start_request, stop_request,
//                                     ack_enable, busy_res, read_byte
// config    APB write/read            paddr, pwdata, prdata
//
// One item is accepted per cycle while in_stall is low; its result is shown the
// cycle after acceptance, as the byte buffer has a registered read port.
// rst is synchronous: it clears the sequencer state (busy starts set) and the
// configuration; the byte buffer is not cleared.
// in_stall is high only while a result is held in the output register and stalled.
module i2c_master_transfer_sequencer_core import i2cms_pkg::*; #(
  parameter int BUF_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [4:0]  buffer_index,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        start_request,
  output logic        stop_request,
  output logic        ack_enable,
  output logic        busy_res,
  output logic [7:0]  read_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  buf_req_t   req;
  step_res_t  step_res;
  step_res_t  res_q;
  logic       step;
  logic       cfg_wr;
  logic [7:0] rd_data;
  logic       rd_ok;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_address <= '0;
      cfg.transfer_kind  <= 1'b0;
      cfg.write_length   <= '0;
      cfg.read_length    <= ReadLenReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TARGET_ADDR: cfg.target_address <= pwdata[6:0];
        REG_XFER_KIND:   cfg.transfer_kind  <= pwdata[0];
        REG_WRITE_LEN:   cfg.write_length   <= pwdata[5:0];
        REG_READ_LEN:    cfg.read_length    <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_sel)
      REG_TARGET_ADDR: prdata = 32'(cfg.target_address);
      REG_XFER_KIND:   prdata = 32'(cfg.transfer_kind);
      REG_WRITE_LEN:   prdata = 32'(cfg.write_length);
      REG_READ_LEN:    prdata = 32'(cfg.read_length);
      default:         prdata = '0;
    endcase
  end

  // An item enters whenever the output register is free or being drained.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  i2cms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .opcode       (opcode),
    .buffer_index (buffer_index),
    .data_in      (data_in),
    .cfg          (cfg),
    .req          (req),
    .res          (step_res)
  );

  i2cms_buf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .step    (step),
    .req     (req),
    .rd_data (rd_data),
    .rd_ok   (rd_ok)
  );

  // Output register; the buffer read data is registered alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  // Merge the buffer byte into the registered result.
  always_comb begin
    tx_valid      = res_q.tx_valid;
    start_request = res_q.start_request;
    stop_request  = res_q.stop_request;
    ack_enable    = res_q.ack_enable;
    busy_res      = res_q.busy;
    if (res_q.tx_from_buf) begin
      tx_byte = rd_ok ? rd_data : 8'd0;
    end else begin
      tx_byte = res_q.addr_byte;
    end
    read_byte = (res_q.readback && rd_ok) ? rd_data : 8'd0;
  end

  // An accepted item always shows up in the output register next cycle.
  assert property (@(posedge clk) disable iff (rst) step |=> out_valid)
    else $error("accepted transaction did not reach the output register");

  // No byte is sent, the sent byte reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tx_valid) |-> (tx_byte == 8'd0))
    else $error("tx_byte nonzero without tx_valid");

  // A readback result carries no bus action.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_byte != 8'd0) |-> (!tx_valid && !start_request && !stop_request))
    else $error("readback result carries a bus action");

  // A step never asks for start and stop together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(start_request && stop_request))
    else $error("start and stop requested in the same result");

endmodule
